// ===== rtl/core/dq_pkg.sv =====
// dq_pkg: shared types and constants of the bounded deque
// beat structs, operation and status codes, default sizes
// no dependencies
package dq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int FUNC_WIDTH  = 3;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_WIDTH   = 4;
   localparam int OCC_WIDTH   = 5;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_READ_AT    = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]  func;
      logic [VALUE_WIDTH-1:0] push_value;
      logic [POS_WIDTH-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] read_value;
      status_type             status;
      logic [OCC_WIDTH-1:0]   occupancy;
   } rsp_type;

   // response info handed from the controller to the output side
   typedef struct packed {
      logic                 valid;
      logic                 use_data;
      status_type           status;
      logic [OCC_WIDTH-1:0] occupancy;
   } rsp_meta_type;

endpackage

// ===== rtl/core/dq_ram.sv =====
// dq_ram: generic single-port RAM with registered read data
// no dependencies
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// dq_ctrl: front pointer, entry count and store access of the deque
// depends on dq_pkg
module dq_ctrl #(
   parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  dq_pkg::req_type              req,
   output logic                         busy,
   output logic                         ram_wr_en,
   output logic                         ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]     ram_addr,
   output dq_pkg::rsp_meta_type         meta
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SUMW = CW + 1;
   localparam int PW   = (CW > dq_pkg::POS_WIDTH) ? CW : dq_pkg::POS_WIDTH;

   logic [AW-1:0]          front_ff, front_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   busy_ff;
   dq_pkg::rsp_meta_type   meta_ff, meta_in;
   logic                   full, empty;
   logic [AW-1:0]          front_dec;

   // front plus offset, modulo the depth
   function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                          input logic [CW-1:0] offset);
      logic [SUMW-1:0] sum;
      sum = SUMW'(base) + SUMW'(offset);
      if (sum >= SUMW'(DEPTH)) begin
         sum = sum - SUMW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);

   always_comb begin
      front_in          = front_ff;
      count_in          = count_ff;
      ram_wr_en         = 1'b0;
      ram_rd_en         = 1'b0;
      ram_addr          = front_ff;
      meta_in.valid     = accept;
      meta_in.use_data  = 1'b0;
      meta_in.status    = dq_pkg::STATUS_OK;
      if (accept) begin
         case (req.func)
            dq_pkg::FUNC_PUSH_FRONT: begin
               if (full) begin
                  meta_in.status = dq_pkg::STATUS_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_addr  = front_dec;
                  front_in  = front_dec;
                  count_in  = count_ff + CW'(1);
               end
            end
            dq_pkg::FUNC_PUSH_BACK: begin
               if (full) begin
                  meta_in.status = dq_pkg::STATUS_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_addr  = wrap(front_ff, count_ff);
                  count_in  = count_ff + CW'(1);
               end
            end
            dq_pkg::FUNC_POP_FRONT: begin
               if (empty) begin
                  meta_in.status = dq_pkg::STATUS_EMPTY;
               end else begin
                  ram_rd_en        = 1'b1;
                  meta_in.use_data = 1'b1;
                  ram_addr         = front_ff;
                  front_in         = wrap(front_ff, CW'(1));
                  count_in         = count_ff - CW'(1);
               end
            end
            dq_pkg::FUNC_POP_BACK: begin
               if (empty) begin
                  meta_in.status = dq_pkg::STATUS_EMPTY;
               end else begin
                  ram_rd_en        = 1'b1;
                  meta_in.use_data = 1'b1;
                  ram_addr         = wrap(front_ff, count_ff - CW'(1));
                  count_in         = count_ff - CW'(1);
               end
            end
            dq_pkg::FUNC_READ_AT: begin
               if (PW'(req.position) >= PW'(count_ff)) begin
                  meta_in.status = dq_pkg::STATUS_RANGE;
               end else begin
                  ram_rd_en        = 1'b1;
                  meta_in.use_data = 1'b1;
                  ram_addr         = wrap(front_ff, CW'(req.position));
               end
            end
            default: begin
            end
         endcase
      end
      meta_in.occupancy = dq_pkg::OCC_WIDTH'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         busy_ff       <= 1'b1;
         meta_ff.valid <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         busy_ff       <= 1'b0;
         meta_ff.valid <= meta_in.valid;
      end
      meta_ff.use_data  <= meta_in.use_data;
      meta_ff.status    <= meta_in.status;
      meta_ff.occupancy <= meta_in.occupancy;
   end

   assign busy = busy_ff;
   assign meta = meta_ff;

endmodule

// ===== rtl/core/bounded_deque_with_indexed_read.sv =====
// bounded_deque_with_indexed_read: top level of the bounded deque
// depends on dq_pkg, dq_ctrl and dq_ram
//
// Usage:
//   A request beat (req_data: func, push_value, position) is taken at a rising
//   clock edge where start is high and busy is low. Operations are push front,
//   push back, pop front, pop back and read at a position from the front.
//   Every request gives exactly one response beat on rsp_data, marked by
//   rsp_valid for one cycle, in the cycle right after the request is taken.
//   The response carries the word popped or read (zero unless status is ok),
//   the status and the entry count after the operation.
//   A new request is taken every cycle while busy is low: the pointer
//   and count update in the accept cycle and the store is accessed at most once per
//   beat through its single port, with the read data registered in the RAM.
//   Reset (synchronous, active high) empties the queue and sets busy, which
//   clears at the first clock edge where reset is low.
//   The receiver cannot stall: each response is valid for its single cycle.
module bounded_deque_with_indexed_read #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  dq_pkg::req_type req_data,
   output logic            rsp_valid,
   output dq_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = (DATA_WIDTH < dq_pkg::VALUE_WIDTH) ? DATA_WIDTH
                                                          : dq_pkg::VALUE_WIDTH;

   logic                 accept;
   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_addr;
   logic [SW-1:0]        ram_rd_data;
   dq_pkg::rsp_meta_type meta;

   assign accept = start && !busy;

   dq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .busy      (busy),
      .ram_wr_en (ram_wr_en),
      .ram_rd_en (ram_rd_en),
      .ram_addr  (ram_addr),
      .meta      (meta)
   );

   dq_ram #(
      .WIDTH(SW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (SW'(req_data.push_value)),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid           = meta.valid;
   assign rsp_data.read_value = meta.use_data ? dq_pkg::VALUE_WIDTH'(ram_rd_data)
                                              : '0;
   assign rsp_data.status     = meta.status;
   assign rsp_data.occupancy  = meta.occupancy;

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request gave no response beat");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response beat without a request");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != dq_pkg::STATUS_OK) |->
         (rsp_data.read_value == '0))
      else $error("nonzero read value on a failed operation");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and written in the same cycle");
`endif

endmodule
